/* design/slid_pkg.sv */
// Package for the sorted list block: list depth, widths, operation and status codes,
// and the command and status structs between the controller and the datapath.
// Has no dependencies.
package slid_pkg;

   localparam int LIST_DEPTH = 32;
   localparam int VALUE_W    = 32;
   localparam int OCC_W      = $clog2(LIST_DEPTH + 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DUMP   = 1'b1;

   typedef enum logic [1:0] {
      STATUS_ENTRY = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_INSERT,
      CMD_FULL,
      CMD_EMPTY,
      CMD_SHIFT
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type op;
   } cmd_type;

   typedef struct packed {
      logic occ_zero;
      logic occ_one;
      logic occ_full;
   } dp_status_type;

endpackage

/* design/slid_datapath.sv */
// Datapath of the sorted list: the row of entry registers, the occupancy count
// and the result register. Depends on slid_pkg for widths, codes and structs.
module slid_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  slid_pkg::cmd_type                   cmd,
   input  logic signed [slid_pkg::VALUE_W-1:0] ins_value,
   output slid_pkg::dp_status_type             status,
   output logic signed [slid_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);

   logic signed [slid_pkg::VALUE_W-1:0] entries_ff [slid_pkg::LIST_DEPTH];
   logic signed [slid_pkg::VALUE_W-1:0] entries_in [slid_pkg::LIST_DEPTH];
   logic [slid_pkg::OCC_W-1:0]          occupancy_ff, occupancy_in;
   logic [slid_pkg::LIST_DEPTH-1:0]     lt;
   logic signed [slid_pkg::VALUE_W-1:0] value_ff, value_in;
   slid_pkg::status_type                code_ff, code_in;
   logic                                last_ff, last_in;

   // Each cell compares against the new value; the sorted order makes lt a prefix.
   always_comb begin
      for (int i = 0; i < slid_pkg::LIST_DEPTH; i++) begin
         lt[i] = (slid_pkg::OCC_W'(i) < occupancy_ff) && (entries_ff[i] < ins_value);
      end
   end

   always_comb begin
      for (int i = 0; i < slid_pkg::LIST_DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
      end
      occupancy_in = occupancy_ff;
      value_in     = value_ff;
      code_in      = code_ff;
      last_in      = last_ff;
      case (cmd.op)
         slid_pkg::CMD_INSERT: begin
            if (!lt[0]) begin
               entries_in[0] = ins_value;
            end
            for (int i = 1; i < slid_pkg::LIST_DEPTH; i++) begin
               if (!lt[i]) begin
                  entries_in[i] = lt[i-1] ? ins_value : entries_ff[i-1];
               end
            end
            occupancy_in = occupancy_ff + 1'b1;
         end
         slid_pkg::CMD_SHIFT: begin
            for (int i = 0; i < slid_pkg::LIST_DEPTH - 1; i++) begin
               entries_in[i] = entries_ff[i+1];
            end
            occupancy_in = occupancy_ff - 1'b1;
            value_in     = entries_ff[0];
            code_in      = slid_pkg::STATUS_ENTRY;
            last_in      = status.occ_one;
         end
         slid_pkg::CMD_FULL: begin
            value_in = '0;
            code_in  = slid_pkg::STATUS_FULL;
            last_in  = 1'b1;
         end
         slid_pkg::CMD_EMPTY: begin
            value_in = '0;
            code_in  = slid_pkg::STATUS_EMPTY;
            last_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < slid_pkg::LIST_DEPTH; i++) begin
         entries_ff[i] <= entries_in[i];
      end
      value_ff <= value_in;
      code_ff  <= code_in;
      last_ff  <= last_in;
      if (reset) begin
         occupancy_ff <= '0;
      end else begin
         occupancy_ff <= occupancy_in;
      end
   end

   assign status.occ_zero = (occupancy_ff == '0);
   assign status.occ_one  = (occupancy_ff == slid_pkg::OCC_W'(1));
   assign status.occ_full = (occupancy_ff == slid_pkg::OCC_W'(slid_pkg::LIST_DEPTH));

   assign rsp_sorted_value = value_ff;
   assign rsp_status       = code_ff;
   assign rsp_last         = last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occupancy_ff <= slid_pkg::OCC_W'(slid_pkg::LIST_DEPTH))
      else $error("occupancy exceeds list depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.op == slid_pkg::CMD_INSERT |=> occupancy_ff == $past(occupancy_ff) + 1'b1)
      else $error("insert did not grow the list by one");

endmodule

/* design/slid_ctrl.sv */
// Controller of the sorted list: handshakes and the idle and dump states.
// Depends on slid_pkg for codes and the command and status structs.
module slid_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_operation,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  slid_pkg::dp_status_type status,
   output slid_pkg::cmd_type       cmd
);

   typedef enum logic {
      IDLE,
      DUMP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == IDLE) && slot_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = slid_pkg::CMD_NONE;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && req_ready) begin
               if (req_operation == slid_pkg::OP_INSERT) begin
                  if (status.occ_full) begin
                     cmd.op       = slid_pkg::CMD_FULL;
                     rsp_valid_in = 1'b1;
                  end else begin
                     cmd.op = slid_pkg::CMD_INSERT;
                  end
               end else if (status.occ_zero) begin
                  cmd.op       = slid_pkg::CMD_EMPTY;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = DUMP;
               end
            end
         end
         DUMP: begin
            if (slot_free) begin
               cmd.op       = slid_pkg::CMD_SHIFT;
               rsp_valid_in = 1'b1;
               if (status.occ_one) begin
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_dump_not_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == DUMP |-> !status.occ_zero)
      else $error("dump state entered with an empty list");

   a_no_accept_in_dump: assert property (@(posedge clock) disable iff (reset)
      state_ff == DUMP |-> !req_ready)
      else $error("request accepted during a dump");

   a_result_not_lost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> cmd.op == slid_pkg::CMD_NONE
         || cmd.op == slid_pkg::CMD_INSERT)
      else $error("result register overwritten while stalled");

endmodule

/* design/sorted_list_insert_and_dump.sv */
// Top level of the sorted list block: joins the controller and the datapath.
// Depends on slid_pkg, slid_ctrl and slid_datapath.
// An insert is stored on acceptance and a new transaction may follow in the next cycle.
// A dump of n values enters the dump state, then gives one result per cycle while
// the receiver takes them, set by the single read port at the head of the entry row;
// an empty dump and a dropped insert give one result in the cycle after acceptance.
// Reset (synchronous, active high) empties the list and drops any pending result.
module sorted_list_insert_and_dump (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [slid_pkg::VALUE_W-1:0] req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [slid_pkg::VALUE_W-1:0] rsp_sorted_value,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_last
);

   // Commands flow from the controller to the datapath; the occupancy flags flow back.
   slid_pkg::cmd_type       cmd;
   slid_pkg::dp_status_type status;

   // The controller owns both handshakes. A result transaction waits in the
   // datapath's result register, and a new request is only taken once that
   // register is empty or is being emptied in the same cycle, so a request can
   // follow a waiting result without a gap but never overtakes it.
   slid_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // The datapath holds the entries as a row of registers kept in ascending
   // order. An insert compares every cell with the new value at once and
   // shifts those greater than or equal to it up by one; a dump shifts the row down, one value
   // per result transaction, taking the head into the result register.
   slid_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .ins_value        (req_value),
      .status           (status),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the sorted list block (sorted_list_insert_and_dump).
// Depends on slid_pkg and the RTL of the block. It predicts every result from its
// own copy of the list and checks each rsp transaction against the oldest prediction.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // A receiver hold must stay well below the watchdog limit. The limit is
   // a count of consecutive cycles in which neither channel moves a transaction.
   localparam int RX_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic signed [slid_pkg::VALUE_W-1:0] sorted_value;
      slid_pkg::status_type                status;
      logic                                last;
   } list_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic                                req_operation = slid_pkg::OP_INSERT;
   logic signed [slid_pkg::VALUE_W-1:0] req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic signed [slid_pkg::VALUE_W-1:0] rsp_sorted_value;
   logic [1:0]                          rsp_status;
   logic                                rsp_last;

   // Own copy of the list contents, kept in ascending order.
   logic signed [slid_pkg::VALUE_W-1:0] list_entries [slid_pkg::LIST_DEPTH];
   int                                  list_count = 0;
   list_result_type                     pending_results [$];

   int   mismatch_count = 0;
   int   tx_idle_pct = 0;
   int   rx_idle_pct = 0;
   int   idle_cycles = 0;
   logic rx_hold_toggle = 1'b0;
   logic rx_hold_seen = 1'b0;
   int   rx_hold_left = 0;

   sorted_list_insert_and_dump dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction of the list behaviour
   // ---------------------------------------------------------------------

   function automatic void push_result(input logic signed [slid_pkg::VALUE_W-1:0] value,
                                       input slid_pkg::status_type status,
                                       input logic last);
      list_result_type item;
      item.sorted_value = value;
      item.status       = status;
      item.last         = last;
      pending_results.push_back(item);
   endfunction

   // Applies one accepted req transaction to the list copy and queues the
   // results that it must cause. A new value goes in front of any stored
   // values that are equal to it, so the search stops at the first entry that
   // is greater than or equal to the new value.
   function automatic void predict_transaction(
         input logic op, input logic signed [slid_pkg::VALUE_W-1:0] value);
      int slot;
      int k;
      if (op == slid_pkg::OP_INSERT) begin
         if (list_count >= slid_pkg::LIST_DEPTH) begin
            push_result('0, slid_pkg::STATUS_FULL, 1'b1);
         end else begin
            slot = list_count;
            for (k = 0; k < list_count; k++) begin
               if (list_entries[k] >= value) begin
                  slot = k;
                  break;
               end
            end
            for (k = list_count; k > slot; k--) begin
               list_entries[k] = list_entries[k-1];
            end
            list_entries[slot] = value;
            list_count++;
         end
      end else if (list_count == 0) begin
         push_result('0, slid_pkg::STATUS_EMPTY, 1'b1);
      end else begin
         for (k = 0; k < list_count; k++) begin
            push_result(list_entries[k], slid_pkg::STATUS_ENTRY, k == list_count - 1);
         end
         list_count = 0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   function automatic void check_result();
      list_result_type want;
      if (pending_results.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected result: value %0d status %0d last %0d",
                     rsp_sorted_value, rsp_status, rsp_last);
         end
      end else begin
         want = pending_results.pop_front();
         if (rsp_sorted_value !== want.sorted_value || rsp_status !== want.status ||
             rsp_last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display({"result mismatch: expected value %0d status %0d last %0d, ",
                         "got value %0d status %0d last %0d"},
                        want.sorted_value, want.status, want.last,
                        rsp_sorted_value, rsp_status, rsp_last);
            end
         end
      end
   endfunction

   // Outputs are sampled at the rising edge, before any nonblocking update of
   // this time step has landed, so both sides see the values of the last cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_result();
      end
   end

   // The receiver refuses results at random, and for a long stretch whenever a
   // test flips rx_hold_toggle. The hold is counted here, in its own process.
   always @(posedge clock) begin
      if (rx_hold_toggle != rx_hold_seen) begin
         rx_hold_seen = rx_hold_toggle;
         rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // The watchdog ends a run in which no transaction moves on either channel
   // for too long; a stuck block would otherwise hang the simulation.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offers one req transaction and returns at the edge where it is taken.
   // The valid is only lowered during an idle gap, so that back-to-back
   // transactions never see a low and a high assignment in the same step.
   task automatic send_item(input logic op,
                            input logic signed [slid_pkg::VALUE_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= value;
      do @(posedge clock); while (!req_ready);
      predict_transaction(op, value);
   endtask

   // Stops offering and waits until every predicted result has been checked.
   // At least one edge passes, so the next valid cannot collide with the low.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Mostly full-range values, with a good share of small values so that ties
   // are frequent, and a few of the extremes.
   function automatic logic signed [slid_pkg::VALUE_W-1:0] random_value();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         return $urandom();
      end else if (pick < 85) begin
         return $urandom_range(6) - 3;
      end else begin
         case ($urandom_range(3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return '0;
            default: return -1;
         endcase
      end
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Directed part straight after reset: the empty dump, both extremes, the
   // all-ones and alternating patterns, and ties among equal values.
   task automatic test_extremes_and_ties();
      send_item(slid_pkg::OP_DUMP, 32'sh7fff_ffff);
      send_item(slid_pkg::OP_INSERT, '0);
      send_item(slid_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_item(slid_pkg::OP_INSERT, 32'sh8000_0000);
      send_item(slid_pkg::OP_INSERT, -1);
      send_item(slid_pkg::OP_INSERT, 5);
      send_item(slid_pkg::OP_INSERT, 5);
      send_item(slid_pkg::OP_INSERT, -1);
      send_item(slid_pkg::OP_INSERT, 32'sh7fff_ffff);
      send_item(slid_pkg::OP_INSERT, 32'sh8000_0000);
      send_item(slid_pkg::OP_DUMP, '0);
      send_item(slid_pkg::OP_DUMP, -1);
      send_item(slid_pkg::OP_INSERT, 32'sh5555_5555);
      send_item(slid_pkg::OP_INSERT, 32'shaaaa_aaaa);
      send_item(slid_pkg::OP_INSERT, 1);
      send_item(slid_pkg::OP_DUMP, 32'sh5555_5555);
   endtask

   // Fills the list to the top and then tries two more inserts, which must be
   // dropped with the full status, before dumping the whole list.
   task automatic test_list_full();
      int k;
      send_item(slid_pkg::OP_DUMP, random_value());
      for (k = 0; k < slid_pkg::LIST_DEPTH + 2; k++) begin
         send_item(slid_pkg::OP_INSERT, random_value());
      end
      send_item(slid_pkg::OP_DUMP, random_value());
   endtask

   // The receiver holds off while the sender keeps offering inserts, so the
   // list fills, a dropped insert waits on the result channel and the block
   // must stall its input until the hold ends.
   task automatic test_receiver_hold();
      int k;
      rx_hold_toggle <= ~rx_hold_toggle;
      for (k = 0; k < slid_pkg::LIST_DEPTH + 8; k++) begin
         send_item(slid_pkg::OP_INSERT, random_value());
      end
      send_item(slid_pkg::OP_DUMP, random_value());
      send_item(slid_pkg::OP_DUMP, random_value());
   endtask

   // The sender pauses until every result is in, then starts afresh on an
   // idle block with a short insert and dump sequence.
   task automatic test_sender_pause();
      int k;
      for (k = 0; k < 4; k++) begin
         send_item(slid_pkg::OP_INSERT, random_value());
      end
      send_item(slid_pkg::OP_DUMP, random_value());
      wait_for_results();
      send_item(slid_pkg::OP_INSERT, random_value());
      send_item(slid_pkg::OP_DUMP, random_value());
   endtask

   // Random sequences: mostly a run of inserts closed by a dump, with short
   // runs most common, some long ones and a few that overrun the list. The
   // remainder is noise: lone dumps and runs left open to pile up.
   task automatic test_random_sequences(input int item_total);
      int sent;
      int run_len;
      int pick;
      int k;
      sent = 0;
      while (sent < item_total) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            run_len = $urandom_range(8);
         end else if (pick < 95) begin
            run_len = $urandom_range(slid_pkg::LIST_DEPTH - 1, 9);
         end else begin
            run_len = $urandom_range(slid_pkg::LIST_DEPTH + 4, slid_pkg::LIST_DEPTH);
         end
         if ($urandom_range(99) < 8) begin
            run_len = 0;
         end
         for (k = 0; k < run_len; k++) begin
            send_item(slid_pkg::OP_INSERT, random_value());
         end
         sent += run_len;
         if ($urandom_range(99) < 90) begin
            send_item(slid_pkg::OP_DUMP, $urandom());
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Run sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Sender seldom idle, receiver mostly stalling.
      tx_idle_pct = 13;
      rx_idle_pct = 65;
      test_extremes_and_ties();
      test_list_full();
      test_random_sequences(100);

      // Sender mostly idle, receiver seldom stalling.
      tx_idle_pct = 65;
      rx_idle_pct = 13;
      test_receiver_hold();
      test_random_sequences(100);

      // Neither side idles.
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_sender_pause();
      test_random_sequences(100);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_results.size() != 0) begin
         mismatch_count += pending_results.size();
         $display("%0d predicted results never arrived", pending_results.size());
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
